FILE: rtl/itc_pkg.sv
package itc_pkg;

    localparam int COORD_BITS_DEF = 16;

    // Depth of the queue between the classifying front and the arithmetic back.
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [QCNT_W-1:0] qfill_t;

    // Classification made by the front and carried with each item.
    typedef struct packed {
        logic collinear;
        logic a_neg;
    } itc_flags_t;

    localparam int FLAGS_W = $bits(itc_flags_t);

endpackage

FILE: rtl/itc_front.sv
module itc_front
    import itc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int DW  = COORD_BITS + 1,
    localparam int PW  = 2 * DW,
    localparam int SW  = PW + 1,
    localparam int QDW = 6 * SW + FLAGS_W
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] ax,
    input  logic signed [COORD_BITS-1:0] ay,
    input  logic signed [COORD_BITS-1:0] bx_in,
    input  logic signed [COORD_BITS-1:0] by_in,
    input  logic signed [COORD_BITS-1:0] cx,
    input  logic signed [COORD_BITS-1:0] cy,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    input  qfill_t                       q_fill,
    output logic                         push,
    output logic [QDW-1:0]               push_data
);

    localparam int AW = SW + 2;

    logic                 accept;
    logic                 v1_reg, v2_reg, v3_reg;
    logic [1:0]           inflight;
    logic [QCNT_W:0]      occupancy;

    logic signed [DW-1:0] dx_next [3];
    logic signed [DW-1:0] dy_next [3];
    logic signed [DW-1:0] dx_reg  [3];
    logic signed [DW-1:0] dy_reg  [3];

    logic signed [PW-1:0] sqx_next [3];
    logic signed [PW-1:0] sqy_next [3];
    logic signed [PW-1:0] xy_next  [3];
    logic signed [PW-1:0] yx_next  [3];
    logic signed [PW-1:0] sqx_reg  [3];
    logic signed [PW-1:0] sqy_reg  [3];
    logic signed [PW-1:0] xy_reg   [3];
    logic signed [PW-1:0] yx_reg   [3];

    logic signed [SW-1:0] s_next [3];
    logic signed [SW-1:0] k_next [3];
    logic signed [SW-1:0] s_reg  [3];
    logic signed [SW-1:0] k_reg  [3];

    logic signed [AW-1:0] a_sum;
    itc_flags_t           flags;

    // Items already in the front pipeline must find room in the queue.
    assign inflight  = 2'(v1_reg) + 2'(v2_reg) + 2'(v3_reg);
    assign occupancy = (QCNT_W + 1)'(q_fill) + (QCNT_W + 1)'(inflight);
    assign busy      = (occupancy >= (QCNT_W + 1)'(QUEUE_DEPTH));
    assign accept    = start & ~busy;

    // Move the test point to the origin; the predicate is translation invariant.
    always_comb
    begin
        dx_next[0] = DW'(ax)    - DW'(px);
        dy_next[0] = DW'(ay)    - DW'(py);
        dx_next[1] = DW'(bx_in) - DW'(px);
        dy_next[1] = DW'(by_in) - DW'(py);
        dx_next[2] = DW'(cx)    - DW'(px);
        dy_next[2] = DW'(cy)    - DW'(py);
    end

    generate
        for (genvar i = 0; i < 3; i++)
        begin : g_corner
            localparam int J = (i + 1) % 3;
            localparam int L = (i + 2) % 3;

            always_comb
            begin
                sqx_next[i] = dx_reg[i] * dx_reg[i];
                sqy_next[i] = dy_reg[i] * dy_reg[i];
                xy_next[i]  = dx_reg[J] * dy_reg[L];
                yx_next[i]  = dx_reg[L] * dy_reg[J];
                s_next[i]   = SW'(sqx_reg[i]) + SW'(sqy_reg[i]);
                k_next[i]   = SW'(xy_reg[i]) - SW'(yx_reg[i]);
            end

            assign push_data[FLAGS_W + (5 - i) * SW +: SW] = s_reg[i];
            assign push_data[FLAGS_W + (2 - i) * SW +: SW] = k_reg[i];
        end
    endgenerate

    // Twice the signed triangle area is the sum of the cross terms of all edges.
    always_comb
    begin
        a_sum           = AW'(k_reg[0]) + AW'(k_reg[1]) + AW'(k_reg[2]);
        flags.collinear = (a_sum == '0);
        flags.a_neg     = a_sum[AW-1];
    end

    assign push_data[FLAGS_W-1:0] = flags;
    assign push                   = v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (v1_reg)
        begin
            sqx_reg <= sqx_next;
            sqy_reg <= sqy_next;
            xy_reg  <= xy_next;
            yx_reg  <= yx_next;
        end
        if (v2_reg)
        begin
            s_reg <= s_next;
            k_reg <= k_next;
        end
    end

endmodule

FILE: rtl/itc_queue.sv
module itc_queue
    import itc_pkg::*;
#(
    parameter int DATA_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              out_valid,
    output logic [DATA_W-1:0] out_data,
    output qfill_t            fill
);

    logic [DATA_W-1:0] mem [QUEUE_DEPTH];

    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    qfill_t            fill_reg, fill_next;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              pop;

    // The back end never stalls, so any stored entry leaves at once.
    assign pop = (fill_reg != '0);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + qfill_t'(push) - qfill_t'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            fill_reg      <= fill_next;
            out_valid_reg <= pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= mem[rd_ptr_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign fill      = fill_reg;

endmodule

FILE: rtl/itc_back.sv
module itc_back
    import itc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int DW  = COORD_BITS + 1,
    localparam int PW  = 2 * DW,
    localparam int SW  = PW + 1,
    localparam int QDW = 6 * SW + FLAGS_W
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [QDW-1:0] in_data,
    output logic           done,
    output logic           inside_res
);

    // Each operand splits into an unsigned low half and a signed high half.
    localparam int H      = (SW + 1) / 2;
    localparam int HW     = SW - H;
    localparam int LHW    = H + 1 + HW;
    localparam int MW     = LHW + 1;
    localparam int PROD_W = 2 * SW;
    localparam int CW     = PROD_W + 2;

    logic signed [SW-1:0] s_w  [3];
    logic signed [SW-1:0] k_w  [3];
    logic [H-1:0]         s_lo [3];
    logic [H-1:0]         k_lo [3];
    logic signed [HW-1:0] s_hi [3];
    logic signed [HW-1:0] k_hi [3];
    itc_flags_t           in_flags;

    logic [2*H-1:0]          ll_next [3];
    logic signed [LHW-1:0]   lh_next [3];
    logic signed [LHW-1:0]   hl_next [3];
    logic signed [2*HW-1:0]  hh_next [3];
    logic [2*H-1:0]          ll_reg  [3];
    logic signed [LHW-1:0]   lh_reg  [3];
    logic signed [LHW-1:0]   hl_reg  [3];
    logic signed [2*HW-1:0]  hh_reg  [3];

    logic signed [MW-1:0]    mid_next [3];
    logic signed [MW-1:0]    mid_reg  [3];
    logic [2*H-1:0]          ll2_reg  [3];
    logic signed [2*HW-1:0]  hh2_reg  [3];

    logic signed [PROD_W-1:0] ll_ext    [3];
    logic signed [PROD_W-1:0] mid_ext   [3];
    logic signed [PROD_W-1:0] hh_ext    [3];
    logic signed [PROD_W-1:0] prod_next [3];
    logic signed [PROD_W-1:0] prod_reg  [3];

    logic signed [CW-1:0] c_sum;
    logic                 inside_next;

    itc_flags_t flags1_reg, flags2_reg, flags3_reg;
    logic       vb1_reg, vb2_reg, vb3_reg;
    logic       done_reg;
    logic       inside_reg;

    assign in_flags = in_data[FLAGS_W-1:0];

    generate
        for (genvar i = 0; i < 3; i++)
        begin : g_prod
            assign s_w[i]  = in_data[FLAGS_W + (5 - i) * SW +: SW];
            assign k_w[i]  = in_data[FLAGS_W + (2 - i) * SW +: SW];
            assign s_lo[i] = s_w[i][H-1:0];
            assign k_lo[i] = k_w[i][H-1:0];
            assign s_hi[i] = s_w[i][SW-1:H];
            assign k_hi[i] = k_w[i][SW-1:H];

            always_comb
            begin
                ll_next[i]   = s_lo[i] * k_lo[i];
                lh_next[i]   = $signed({1'b0, s_lo[i]}) * k_hi[i];
                hl_next[i]   = s_hi[i] * $signed({1'b0, k_lo[i]});
                hh_next[i]   = s_hi[i] * k_hi[i];
                mid_next[i]  = MW'(lh_reg[i]) + MW'(hl_reg[i]);
                ll_ext[i]    = {{(PROD_W - 2 * H){1'b0}}, ll2_reg[i]};
                mid_ext[i]   = PROD_W'(mid_reg[i]);
                hh_ext[i]    = PROD_W'(hh2_reg[i]);
                prod_next[i] = ll_ext[i] + (mid_ext[i] <<< H) + (hh_ext[i] <<< (2 * H));
            end
        end
    endgenerate

    // The point is inside when the lifted determinant is nonzero and has the sign of the area, or when collinear.
    always_comb
    begin
        c_sum       = CW'(prod_reg[0]) + CW'(prod_reg[1]) + CW'(prod_reg[2]);
        inside_next = flags3_reg.collinear
                    | ((c_sum != '0) & (c_sum[CW-1] == flags3_reg.a_neg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb1_reg  <= 1'b0;
            vb2_reg  <= 1'b0;
            vb3_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vb1_reg  <= in_valid;
            vb2_reg  <= vb1_reg;
            vb3_reg  <= vb2_reg;
            done_reg <= vb3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            ll_reg     <= ll_next;
            lh_reg     <= lh_next;
            hl_reg     <= hl_next;
            hh_reg     <= hh_next;
            flags1_reg <= in_flags;
        end
        if (vb1_reg)
        begin
            mid_reg    <= mid_next;
            ll2_reg    <= ll_reg;
            hh2_reg    <= hh_reg;
            flags2_reg <= flags1_reg;
        end
        if (vb2_reg)
        begin
            prod_reg   <= prod_next;
            flags3_reg <= flags2_reg;
        end
        if (vb3_reg)
        begin
            inside_reg <= inside_next;
        end
    end

    assign done       = done_reg;
    assign inside_res = inside_reg;

endmodule

FILE: rtl/incircle_test_core.sv
// Strict in-circle test for Delaunay triangulation.
// A query is three triangle corners (ax,ay), (bx_in,by_in), (cx,cy) and a test
// point (px,py), signed COORD_BITS-bit coordinates. Drive the query with start
// high; it is taken at the rising edge where start is high and busy is low.
// Each taken query gives one beat on the result side: done is high for exactly
// one cycle with inside_res valid. inside_res is 1 when the point lies strictly
// inside the circumcircle, or when the corners are collinear; a point on the
// circle gives 0.
// Throughput is one query per cycle. The front stages translate, square and
// classify; a small queue sits between them and the multiply stages, and busy
// rises only when that queue could overflow, which a steady stream never does.
// Results come out in query order. The receiver cannot hold off a result beat:
// done must be sampled in the cycle it is high.
// Reset (rst_n low, asynchronous) empties the pipeline and the queue; no beat
// is produced for a query that was in flight. No state links one query to the
// next.
module incircle_test_core
    import itc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] ax,
    input  logic signed [COORD_BITS-1:0] ay,
    input  logic signed [COORD_BITS-1:0] bx_in,
    input  logic signed [COORD_BITS-1:0] by_in,
    input  logic signed [COORD_BITS-1:0] cx,
    input  logic signed [COORD_BITS-1:0] cy,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    output logic                         done,
    output logic                         inside_res
);

    localparam int SW  = 2 * (COORD_BITS + 1) + 1;
    localparam int QDW = 6 * SW + FLAGS_W;

    logic           push;
    logic [QDW-1:0] push_data;
    logic           q_valid;
    logic [QDW-1:0] q_data;
    qfill_t         q_fill;

    itc_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .ax        (ax),
        .ay        (ay),
        .bx_in     (bx_in),
        .by_in     (by_in),
        .cx        (cx),
        .cy        (cy),
        .px        (px),
        .py        (py),
        .q_fill    (q_fill),
        .push      (push),
        .push_data (push_data)
    );

    itc_queue #(
        .DATA_W (QDW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .out_valid (q_valid),
        .out_data  (q_data),
        .fill      (q_fill)
    );

    itc_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_valid),
        .in_data    (q_data),
        .done       (done),
        .inside_res (inside_res)
    );

endmodule

FILE: tb/testbench.sv
module testbench;
    import itc_pkg::*;

    localparam int CW         = COORD_BITS_DEF;
    localparam int N_RANDOM   = 1000;
    localparam int IDLE_LIMIT = 1000;
    localparam int DRAIN_WAIT = 20;
    localparam int N_ROWS     = 20;

    typedef logic signed [255:0] wide_t;

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
    } query_t;

    typedef enum int {BY_PREDICTOR, KNOWN_OUT, KNOWN_IN} check_kind_e;

    // Directed rows: three corners, test point, and how the beat is checked.
    localparam int STIM [N_ROWS][9] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0, KNOWN_IN},
        '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, KNOWN_IN},
        '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, KNOWN_IN},
        '{-32768, -32768, 0, 0, 32767, 32767, 32767, -32768, BY_PREDICTOR},
        '{0, 0, 2, 0, 0, 2, 1, 1, KNOWN_IN},
        '{0, 0, 2, 0, 0, 2, 2, 2, KNOWN_OUT},
        '{0, 0, 2, 0, 0, 2, 100, 100, KNOWN_OUT},
        '{0, 0, 0, 2, 2, 0, 1, 1, KNOWN_IN},
        '{0, 0, 2, 0, 0, 2, 0, 0, KNOWN_OUT},
        '{-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767, KNOWN_OUT},
        '{-32768, -32768, 32767, -32768, -32768, 32767, 0, 0, KNOWN_IN},
        '{-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32766, BY_PREDICTOR},
        '{-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767, KNOWN_OUT},
        '{32767, -32768, -32768, 32767, -32768, -32768, -32768, -32768, KNOWN_OUT},
        '{32767, 32767, -32768, 32767, 32767, -32768, -32768, -32768, KNOWN_OUT},
        '{-32768, 0, 32767, 0, 0, 1, 0, -32768, BY_PREDICTOR},
        '{5, -32768, 5, 0, 5, 32767, 0, 0, KNOWN_IN},
        '{7, 7, 7, 7, -3, 4, 1, 1, KNOWN_IN},
        '{1000, -2000, -3000, 4000, 12345, -321, 0, 0, BY_PREDICTOR},
        '{-1, -1, 1, -1, -1, 1, 1, 1, KNOWN_OUT}
    };

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [CW-1:0] ax, ay, bx_in, by_in, cx, cy, px, py;
    logic done;
    logic inside_res;

    logic inside_q [$];
    int   mismatches;
    int   idle_cycles;

    incircle_test_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .ax         (ax),
        .ay         (ay),
        .bx_in      (bx_in),
        .by_in      (by_in),
        .cx         (cx),
        .cy         (cy),
        .px         (px),
        .py         (py),
        .done       (done),
        .inside_res (inside_res)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic wide_t det3(input wide_t e11, e12, e13, e21, e22, e23,
                                   e31, e32, e33);
        wide_t t1, t2, t3;
        t1 = e11 * (e22 * e33 - e32 * e23);
        t2 = e12 * (e21 * e33 - e31 * e23);
        t3 = e13 * (e21 * e32 - e31 * e22);
        return t1 - t2 + t3;
    endfunction

    // Exact in-circle decision; every term is formed at 256 bits, signed.
    function automatic logic circle_contains(input query_t q);
        wide_t x0, y0, x1, y1, x2, y2, qx, qy, s0, s1, s2, one;
        wide_t a, bxd, byd, c, dx, dy, lhs, rhs;
        x0 = q.ax;
        y0 = q.ay;
        x1 = q.bx;
        y1 = q.by;
        x2 = q.cx;
        y2 = q.cy;
        qx = q.px;
        qy = q.py;
        one = 1;
        s0 = x0 * x0 + y0 * y0;
        s1 = x1 * x1 + y1 * y1;
        s2 = x2 * x2 + y2 * y2;
        a = det3(x0, y0, one, x1, y1, one, x2, y2, one);
        // Collinear corners make the circle unbounded.
        if (a == 0)
            return 1'b1;
        bxd = det3(s0, y0, one, s1, y1, one, s2, y2, one);
        byd = det3(s0, x0, one, s1, x1, one, s2, x2, one);
        c   = det3(s0, x0, y0, s1, x1, y1, s2, x2, y2);
        dx  = bxd - 2 * a * qx;
        dy  = byd + 2 * a * qy;
        lhs = dx * dx + dy * dy;
        rhs = bxd * bxd + byd * byd + 4 * a * c;
        return (lhs < rhs) ? 1'b1 : 1'b0;
    endfunction

    function automatic int rand_span(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo, 0));
    endfunction

    function automatic query_t random_query();
        query_t q;
        int     mode, bxo, byo, ddx, ddy, k1, k2, x0, x1, y0, y1;
        mode = int'($urandom_range(9, 0));
        q = {$urandom, $urandom, $urandom, $urandom};
        case (mode)
            3, 4:
            begin
                // Tiny grid: collinear and cocircular sets come up often.
                q.ax = CW'(rand_span(-8, 8));
                q.ay = CW'(rand_span(-8, 8));
                q.bx = CW'(rand_span(-8, 8));
                q.by = CW'(rand_span(-8, 8));
                q.cx = CW'(rand_span(-8, 8));
                q.cy = CW'(rand_span(-8, 8));
                q.px = CW'(rand_span(-8, 8));
                q.py = CW'(rand_span(-8, 8));
            end
            5:
            begin
                bxo = rand_span(-20000, 20000);
                byo = rand_span(-20000, 20000);
                ddx = rand_span(-64, 64);
                ddy = rand_span(-64, 64);
                k1  = rand_span(-100, 100);
                k2  = rand_span(-100, 100);
                q.ax = CW'(bxo);
                q.ay = CW'(byo);
                q.bx = CW'(bxo + ddx * k1);
                q.by = CW'(byo + ddy * k1);
                q.cx = CW'(bxo + ddx * k2);
                q.cy = CW'(byo + ddy * k2);
            end
            6, 7:
            begin
                // Three corners of a rectangle; the fourth is on the circle, the test point at or next to it.
                x0 = rand_span(-32768, 32767);
                x1 = rand_span(-32768, 32767);
                y0 = rand_span(-32768, 32767);
                y1 = rand_span(-32768, 32767);
                q.ax = CW'(x0);
                q.ay = CW'(y0);
                q.bx = CW'(x1);
                q.by = CW'(y0);
                q.cx = CW'(x0);
                q.cy = CW'(y1);
                q.px = CW'(x1 + rand_span(-1, 1));
                q.py = CW'(y1 + rand_span(-1, 1));
            end
            8, 9:
            begin
                q.ax = CW'(rand_span(-1000, 1000));
                q.ay = CW'(rand_span(-1000, 1000));
                q.bx = CW'(rand_span(-1000, 1000));
                q.by = CW'(rand_span(-1000, 1000));
                q.cx = CW'(rand_span(-1000, 1000));
                q.cy = CW'(rand_span(-1000, 1000));
                q.px = CW'(rand_span(-1200, 1200));
                q.py = CW'(rand_span(-1200, 1200));
            end
            default:
            begin
            end
        endcase
        return q;
    endfunction

    task automatic report_mismatch(input string what, input logic got, input logic want);
        $display("mismatch at %0t: %s, got %b want %b", $time, what, got, want);
        mismatches++;
    endtask

    // Hold start low for a random gap, present the query, and wait for the
    // edge that takes it.
    task automatic send_query(input query_t q, input check_kind_e kind);
        int gap;
        gap = int'($urandom_range(17, 0));
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        ax    <= q.ax;
        ay    <= q.ay;
        bx_in <= q.bx;
        by_in <= q.by;
        cx    <= q.cx;
        cy    <= q.cy;
        px    <= q.px;
        py    <= q.py;
        do
            @(posedge clk);
        while (busy);
        case (kind)
            KNOWN_IN:  inside_q.push_back(1'b1);
            KNOWN_OUT: inside_q.push_back(1'b0);
            default:   inside_q.push_back(circle_contains(q));
        endcase
    endtask

    always @(posedge clk)
    begin
        logic want;
        if (rst_n && done)
        begin
            if (inside_q.size() == 0)
                report_mismatch("result beat with nothing pending", inside_res, 1'bx);
            else
            begin
                want = inside_q.pop_front();
                if (inside_res !== want)
                    report_mismatch("inside_res", inside_res, want);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[incircle_test_core] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        query_t q;
        rst_n <= 1'b0;
        start <= 1'b0;
        ax    <= '0;
        ay    <= '0;
        bx_in <= '0;
        by_in <= '0;
        cx    <= '0;
        cy    <= '0;
        px    <= '0;
        py    <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_ROWS; i++)
        begin
            q.ax = CW'(STIM[i][0]);
            q.ay = CW'(STIM[i][1]);
            q.bx = CW'(STIM[i][2]);
            q.by = CW'(STIM[i][3]);
            q.cx = CW'(STIM[i][4]);
            q.cy = CW'(STIM[i][5]);
            q.px = CW'(STIM[i][6]);
            q.py = CW'(STIM[i][7]);
            send_query(q, check_kind_e'(STIM[i][8]));
        end

        for (int i = 0; i < N_RANDOM; i++)
        begin
            // Every so often run a stretch with no gaps at all.
            if (i % 200 < 40)
            begin
                q = random_query();
                start <= 1'b1;
                ax    <= q.ax;
                ay    <= q.ay;
                bx_in <= q.bx;
                by_in <= q.by;
                cx    <= q.cx;
                cy    <= q.cy;
                px    <= q.px;
                py    <= q.py;
                do
                    @(posedge clk);
                while (busy);
                inside_q.push_back(circle_contains(q));
            end
            else
                send_query(random_query(), BY_PREDICTOR);
        end
        start <= 1'b0;

        while (inside_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0)
            $display("[incircle_test_core] OK");
        else
            $display("[incircle_test_core] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/itc_pkg.sv
rtl/itc_front.sv
rtl/itc_queue.sv
rtl/itc_back.sv
rtl/incircle_test_core.sv
tb/testbench.sv
